>>> sv/msf_pkg.sv
// Package: shared constants and types for the missing sequence finder
package msf_pkg;

  localparam int SEQ_SPACE = 1024;
  localparam int SEQ_W     = 10;
  localparam int SCAN_W    = SEQ_W + 1;
  localparam int ROW_W     = 64;
  localparam int BIT_AW    = $clog2(ROW_W);
  localparam int MAP_AW    = $clog2(SEQ_SPACE);
  localparam int ROWS      = SEQ_SPACE / ROW_W;
  localparam int ROW_AW    = MAP_AW - BIT_AW;
  localparam int COUNT_MAX = 1023;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_FETCH  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  typedef struct packed {
    logic              hit;
    logic [BIT_AW-1:0] idx;
  } scan_res_t;

endpackage

>>> sv/msf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module msf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/msf_row_scan.sv
// Row scanner: lowest unreceived bit of one bitmap row within a bit window
module msf_row_scan (
  input  logic [msf_pkg::ROW_W-1:0]  row_data,
  input  logic [msf_pkg::BIT_AW-1:0] lo,
  input  logic [msf_pkg::BIT_AW-1:0] hi,
  output msf_pkg::scan_res_t         res
);
  import msf_pkg::*;

  logic [ROW_W-1:0] cand;

  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      cand[i] = !row_data[i] && (BIT_AW'(i) >= lo) && (BIT_AW'(i) <= hi);
    end
  end

  always_comb begin
    res.hit = 1'b0;
    res.idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res.hit = 1'b1;
        res.idx = BIT_AW'(i);
      end
    end
  end

endmodule

>>> sv/missing_sequence_finder_unit.sv
// Top level: missing sequence number finder over a row-organized bitmap RAM
//
// Received numbers live in a 16 x 64-bit bitmap RAM with registered read data;
// a per-row valid bit, cleared at once by reset or a clear item, makes an unwritten
// row read as all zero, so there is no clearing pass. A clear, an unused opcode, a
// rejected record or a fetch whose scan is already past its end answers in the cycle
// after start and leaves busy low. A good record reads, modifies and writes back one
// row in ST_REC, with busy high only there, and registers its result as it leaves.
// A fetch checks one bitmap row per cycle from the scan position to the scan end and
// stops at the first row with a missing number. Each result is shown for
// exactly one cycle with out_valid high and cannot be held off: capture it then.
module missing_sequence_finder_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_opcode,
  input  logic [msf_pkg::SEQ_W-1:0]  in_total,
  input  logic [msf_pkg::SEQ_W-1:0]  in_seq,
  output logic                       out_valid,
  output logic [msf_pkg::SEQ_W-1:0]  out_missing_seq,
  output logic                       out_found,
  output logic                       out_done_res,
  output logic [msf_pkg::SEQ_W-1:0]  out_packet_count,
  output logic                       out_complete,
  output logic                       out_bad_seq
);
  import msf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_REC  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [ROWS-1:0]   row_valid_r, row_valid_nxt;
  logic [SEQ_W-1:0]  total_r, total_nxt;
  logic [SEQ_W-1:0]  highest_r, highest_nxt;
  logic [SEQ_W-1:0]  count_r, count_nxt;
  logic [SCAN_W-1:0] scan_pos_r, scan_pos_nxt;
  logic [ROW_AW-1:0] cur_row_r, cur_row_nxt;
  logic              first_r, first_nxt;
  logic [SEQ_W-1:0]  rec_seq_r, rec_seq_nxt;
  logic [SEQ_W-1:0]  rec_total_r, rec_total_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SEQ_W-1:0]  out_miss_r, out_miss_nxt;
  logic              out_found_r, out_found_nxt;
  logic              out_done_r, out_done_nxt;
  logic [SEQ_W-1:0]  out_count_r, out_count_nxt;
  logic              out_complete_r, out_complete_nxt;
  logic              out_bad_r, out_bad_nxt;

  logic              accept;
  logic [SEQ_W-1:0]  max_seen;
  logic [SEQ_W-1:0]  lim;
  logic [ROW_AW-1:0] lim_row;
  logic              seq_bad;
  logic [ROW_AW-1:0] ram_raddr;
  logic [ROW_W-1:0]  ram_rdata;
  logic              ram_we;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  row_eff;
  logic [BIT_AW-1:0] scan_lo;
  logic [BIT_AW-1:0] scan_hi;
  scan_res_t         scan_res;
  logic [SEQ_W-1:0]  hit_seq;
  logic [SEQ_W-1:0]  rec_cnt;
  logic [SEQ_W-1:0]  rec_high;

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign max_seen = (total_r > highest_r) ? total_r : highest_r;
  assign lim      = (32'(max_seen) > SEQ_SPACE - 1) ? SEQ_W'(SEQ_SPACE - 1) : max_seen;
  assign lim_row  = lim[MAP_AW-1:BIT_AW];
  assign seq_bad  = (in_seq == '0) || (32'(in_seq) >= SEQ_SPACE);

  always_comb begin
    ram_raddr = cur_row_r + ROW_AW'(1);
    if (state_r == ST_IDLE) begin
      if (in_opcode == OP_RECORD) begin
        ram_raddr = in_seq[MAP_AW-1:BIT_AW];
      end else begin
        ram_raddr = scan_pos_r[MAP_AW-1:BIT_AW];
      end
    end
  end

  assign row_eff   = row_valid_r[cur_row_r] ? ram_rdata : '0;
  assign scan_lo   = first_r ? scan_pos_r[BIT_AW-1:0] : '0;
  assign scan_hi   = (cur_row_r == lim_row) ? lim[BIT_AW-1:0] : '1;
  assign hit_seq   = SEQ_W'({cur_row_r, scan_res.idx});

  assign ram_we    = (state_r == ST_REC);
  assign ram_wdata = (row_valid_r[rec_seq_r[MAP_AW-1:BIT_AW]] ? ram_rdata : '0)
                   | (ROW_W'(1) << rec_seq_r[BIT_AW-1:0]);
  assign rec_cnt   = (32'(count_r) < COUNT_MAX) ? count_r + SEQ_W'(1) : count_r;
  assign rec_high  = (rec_seq_r > highest_r) ? rec_seq_r : highest_r;

  msf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rec_seq_r[MAP_AW-1:BIT_AW]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  msf_row_scan u_row_scan (
    .row_data (row_eff),
    .lo       (scan_lo),
    .hi       (scan_hi),
    .res      (scan_res)
  );

  always_comb begin
    state_nxt        = state_r;
    row_valid_nxt    = row_valid_r;
    total_nxt        = total_r;
    highest_nxt      = highest_r;
    count_nxt        = count_r;
    scan_pos_nxt     = scan_pos_r;
    cur_row_nxt      = cur_row_r;
    first_nxt        = first_r;
    rec_seq_nxt      = rec_seq_r;
    rec_total_nxt    = rec_total_r;
    out_valid_nxt    = 1'b0;
    out_miss_nxt     = '0;
    out_found_nxt    = 1'b0;
    out_done_nxt     = 1'b0;
    out_count_nxt    = count_r;
    out_complete_nxt = (count_r == total_r);
    out_bad_nxt      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            OP_RECORD: begin
              if (seq_bad) begin
                out_valid_nxt = 1'b1;
                out_bad_nxt   = 1'b1;
              end else begin
                rec_seq_nxt   = in_seq;
                rec_total_nxt = in_total;
                state_nxt     = ST_REC;
              end
            end
            OP_FETCH: begin
              if (scan_pos_r <= {1'b0, lim}) begin
                cur_row_nxt = scan_pos_r[MAP_AW-1:BIT_AW];
                first_nxt   = 1'b1;
                state_nxt   = ST_SCAN;
              end else begin
                out_valid_nxt = 1'b1;
                out_done_nxt  = 1'b1;
              end
            end
            OP_CLEAR: begin
              row_valid_nxt    = '0;
              total_nxt        = '0;
              highest_nxt      = '0;
              count_nxt        = '0;
              scan_pos_nxt     = SCAN_W'(1);
              out_valid_nxt    = 1'b1;
              out_count_nxt    = '0;
              out_complete_nxt = 1'b1;
            end
            OP_NOP: begin
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_REC: begin
        row_valid_nxt[rec_seq_r[MAP_AW-1:BIT_AW]] = 1'b1;
        total_nxt        = rec_total_r;
        highest_nxt      = rec_high;
        count_nxt        = rec_cnt;
        out_valid_nxt    = 1'b1;
        out_count_nxt    = rec_cnt;
        out_complete_nxt = (rec_cnt == rec_total_r);
        state_nxt        = ST_IDLE;
      end
      ST_SCAN: begin
        first_nxt = 1'b0;
        if (scan_res.hit) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_miss_nxt  = hit_seq;
          scan_pos_nxt  = {1'b0, hit_seq} + SCAN_W'(1);
          state_nxt     = ST_IDLE;
        end else if (cur_row_r == lim_row) begin
          out_valid_nxt = 1'b1;
          out_done_nxt  = 1'b1;
          scan_pos_nxt  = {1'b0, lim} + SCAN_W'(1);
          state_nxt     = ST_IDLE;
        end else begin
          cur_row_nxt = cur_row_r + ROW_AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_valid_r <= '0;
      total_r     <= '0;
      highest_r   <= '0;
      count_r     <= '0;
      scan_pos_r  <= SCAN_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_valid_r <= row_valid_nxt;
      total_r     <= total_nxt;
      highest_r   <= highest_nxt;
      count_r     <= count_nxt;
      scan_pos_r  <= scan_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_row_r      <= cur_row_nxt;
    first_r        <= first_nxt;
    rec_seq_r      <= rec_seq_nxt;
    rec_total_r    <= rec_total_nxt;
    out_miss_r     <= out_miss_nxt;
    out_found_r    <= out_found_nxt;
    out_done_r     <= out_done_nxt;
    out_count_r    <= out_count_nxt;
    out_complete_r <= out_complete_nxt;
    out_bad_r      <= out_bad_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_missing_seq  = out_miss_r;
  assign out_found        = out_found_r;
  assign out_done_res     = out_done_r;
  assign out_packet_count = out_count_r;
  assign out_complete     = out_complete_r;
  assign out_bad_seq      = out_bad_r;

endmodule

>>> bench/tb.sv
// Testbench for missing_sequence_finder_unit: random and directed items checked against a bitmap predictor
`timescale 1ns / 100ps

module tb;
  import msf_pkg::*;

  typedef struct {
    logic [1:0]       op;
    logic [SEQ_W-1:0] total;
    logic [SEQ_W-1:0] seq;
    int               gap;
    bit               hold;
  } cmd_t;

  typedef struct packed {
    logic [SEQ_W-1:0] missing;
    logic             found;
    logic             done;
    logic [SEQ_W-1:0] count;
    logic             complete;
    logic             bad;
  } report_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [1:0]       in_opcode = OP_NOP;
  logic [SEQ_W-1:0] in_total = '0;
  logic [SEQ_W-1:0] in_seq = '0;
  logic             busy;
  logic             out_valid;
  logic [SEQ_W-1:0] out_missing_seq;
  logic             out_found;
  logic             out_done_res;
  logic [SEQ_W-1:0] out_packet_count;
  logic             out_complete;
  logic             out_bad_seq;

  cmd_t    cmd_q[$];
  report_t report_q[$];

  bit               seen_map[SEQ_SPACE];
  logic [SEQ_W-1:0] burst_total;
  logic [SEQ_W-1:0] max_seq;
  logic [SEQ_W-1:0] rx_count;
  int               scan_ptr;

  logic took = 1'b0;
  bit   primed = 1'b0;
  int   gap_left = 0;
  int   fails = 0;
  int   idle_pct = 0;
  int   n_cmds = 0;

  missing_sequence_finder_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_total         (in_total),
    .in_seq           (in_seq),
    .out_valid        (out_valid),
    .out_missing_seq  (out_missing_seq),
    .out_found        (out_found),
    .out_done_res     (out_done_res),
    .out_packet_count (out_packet_count),
    .out_complete     (out_complete),
    .out_bad_seq      (out_bad_seq)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_tracker();
    foreach (seen_map[i]) seen_map[i] = 1'b0;
    burst_total = '0;
    max_seq = '0;
    rx_count = '0;
    scan_ptr = 1;
  endfunction

  function automatic report_t seq_tracker_step(logic [1:0] op, logic [SEQ_W-1:0] tot,
                                               logic [SEQ_W-1:0] sq);
    report_t r;
    int      lim;
    int      p;
    r = '0;
    case (op)
      OP_RECORD: begin
        if (sq == 0 || int'(sq) >= SEQ_SPACE) begin
          r.bad = 1'b1;
        end else begin
          seen_map[sq] = 1'b1;
          if (sq > max_seq) max_seq = sq;
          burst_total = tot;
          if (int'(rx_count) < COUNT_MAX) rx_count = rx_count + SEQ_W'(1);
        end
      end
      OP_FETCH: begin
        lim = (burst_total > max_seq) ? int'(burst_total) : int'(max_seq);
        if (lim > SEQ_SPACE - 1) lim = SEQ_SPACE - 1;
        p = scan_ptr;
        while (p <= lim && seen_map[p & (SEQ_SPACE - 1)]) p++;
        if (p <= lim) begin
          r.missing = p[SEQ_W-1:0];
          r.found = 1'b1;
          scan_ptr = p + 1;
        end else begin
          r.done = 1'b1;
          if (scan_ptr < lim + 1) scan_ptr = lim + 1;
        end
      end
      OP_CLEAR: clear_tracker();
      default: ;
    endcase
    r.count = rx_count;
    r.complete = (rx_count == burst_total);
    return r;
  endfunction

  function automatic void flag(string msg);
    if (fails < 10) $display("%0t ns: %s", $time, msg);
    fails++;
  endfunction

  function automatic void check_field(string fname, logic [SEQ_W-1:0] want,
                                      logic [SEQ_W-1:0] got);
    if (got !== want) flag($sformatf("%s mismatch: expected %0d, got %0d", fname, want, got));
  endfunction

  function automatic void add(logic [1:0] op, logic [SEQ_W-1:0] tot, logic [SEQ_W-1:0] sq);
    cmd_t c;
    c.op = op;
    c.total = tot;
    c.seq = sq;
    c.hold = 1'b0;
    c.gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    cmd_q.push_back(c);
    if (op != OP_NOP) n_cmds++;
  endfunction

  function automatic void add_hold();
    cmd_t c;
    c.op = OP_NOP;
    c.total = '0;
    c.seq = '0;
    c.gap = 0;
    c.hold = 1'b1;
    cmd_q.push_back(c);
  endfunction

  // drive items at the falling edge, hold each until accepted
  always @(negedge clk) begin : drv
    logic go;
    go = 1'b0;
    if (took) begin
      cmd_q.delete(0);
      primed = 1'b0;
    end
    if (cmd_q.size() != 0) begin
      if (!primed) begin
        gap_left = cmd_q[0].gap;
        primed = 1'b1;
      end
      if (cmd_q[0].hold) begin
        if (report_q.size() == 0 && !busy) begin
          cmd_q.delete(0);
          primed = 1'b0;
        end
      end else if (gap_left != 0) begin
        gap_left--;
      end else begin
        go = 1'b1;
      end
    end
    start <= go;
    if (go) begin
      in_opcode <= cmd_q[0].op;
      in_total <= cmd_q[0].total;
      in_seq <= cmd_q[0].seq;
    end
  end

  always @(posedge clk) begin : mon
    report_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (report_q.size() == 0) begin
        flag("result with no item pending");
      end else begin
        want = report_q.pop_front();
        check_field("missing_seq", want.missing, out_missing_seq);
        check_field("found", SEQ_W'(want.found), SEQ_W'(out_found));
        check_field("done_res", SEQ_W'(want.done), SEQ_W'(out_done_res));
        check_field("packet_count", want.count, out_packet_count);
        check_field("complete", SEQ_W'(want.complete), SEQ_W'(out_complete));
        check_field("bad_seq", SEQ_W'(want.bad), SEQ_W'(out_bad_seq));
      end
    end
    if (rst_n && start && !busy) report_q.push_back(seq_tracker_step(in_opcode, in_total, in_seq));
    took <= rst_n && start && !busy;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stim
    int list[$];
    int n;
    int j;
    int t;
    int kept;
    int tot;
    int base;
    clear_tracker();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 30;
    add(OP_FETCH, 10'h3FF, 10'h3FF);
    add(OP_NOP, 10'h3FF, 10'h3FF);
    add(OP_RECORD, 10'd1023, 10'd0);
    add(OP_RECORD, 10'd5, 10'd1);
    add(OP_RECORD, 10'd5, 10'd1);
    add(OP_FETCH, 10'd0, 10'd0);
    add(OP_RECORD, 10'd5, 10'd3);
    add(OP_FETCH, 10'd0, 10'd0);
    add(OP_FETCH, 10'd0, 10'd0);
    add(OP_FETCH, 10'd0, 10'd0);
    add(OP_FETCH, 10'd0, 10'd0);
    add(OP_RECORD, 10'd5, 10'd8);
    add(OP_FETCH, 10'd0, 10'd0);
    add(OP_RECORD, 10'd0, 10'd1023);
    add(OP_FETCH, 10'd0, 10'd0);
    add(OP_FETCH, 10'd0, 10'd0);
    add(OP_CLEAR, 10'h3FF, 10'h3FF);
    add(OP_FETCH, 10'd0, 10'd0);
    add(OP_RECORD, 10'd2, 10'd2);
    add(OP_RECORD, 10'd2, 10'd1);
    add(OP_FETCH, 10'd0, 10'd0);
    add(OP_NOP, 10'd0, 10'd0);
    add_hold();

    // saturate the packet counter with a nearly full map
    idle_pct = 20;
    add(OP_CLEAR, SEQ_W'($urandom), SEQ_W'($urandom));
    for (int k = 0; k < 1030; k++) begin
      t = (k % 1023) + 1;
      if ($urandom_range(0, 199) == 0) t = 1;
      add(OP_RECORD, 10'd1023, SEQ_W'(t));
    end
    repeat (8) add(OP_FETCH, SEQ_W'($urandom), SEQ_W'($urandom));
    add_hold();

    base = n_cmds;
    while (n_cmds < base + 60) begin
      case ($urandom_range(0, 3))
        0, 1: idle_pct = 0;
        2: idle_pct = 30;
        default: idle_pct = 60;
      endcase
      if (n_cmds > base + 40) idle_pct = 0;
      if (n_cmds <= base + 40 && $urandom_range(0, 7) == 0) add_hold();
      if ($urandom_range(0, 5) != 0) add(OP_CLEAR, SEQ_W'($urandom), SEQ_W'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(3, 12))
          add(2'($urandom_range(0, 3)), SEQ_W'($urandom), SEQ_W'($urandom));
      end else begin
        list.delete();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(61, 1023) : $urandom_range(1, 60);
        if (n <= 60) begin
          for (int k = 1; k <= n; k++)
            if ($urandom_range(0, 99) < 85) list.push_back(k);
          kept = list.size();
          if (kept != 0)
            repeat ($urandom_range(0, 3)) list.push_back(list[$urandom_range(0, kept - 1)]);
          for (int i = list.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = list[i];
            list[i] = list[j];
            list[j] = t;
          end
        end else begin
          repeat ($urandom_range(5, 25)) list.push_back($urandom_range(1, n));
          if ($urandom_range(0, 1) == 0) list.push_back(n);
          kept = n - 16;
        end
        foreach (list[i]) begin
          tot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : n;
          if ($urandom_range(0, 9) == 0) add(OP_FETCH, SEQ_W'($urandom), SEQ_W'($urandom));
          if ($urandom_range(0, 29) == 0) add(OP_RECORD, SEQ_W'(tot), 10'd0);
          add(OP_RECORD, SEQ_W'(tot), SEQ_W'(list[i]));
        end
        repeat (n - kept + $urandom_range(1, 2))
          add(OP_FETCH, SEQ_W'($urandom), SEQ_W'($urandom));
      end
    end

    while (cmd_q.size() != 0 || report_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
